// ===== src/two_server_job_dispatcher_assert.svh =====
// Assertion macros used by the dispatcher's port-level checker
`ifndef TWO_SERVER_JOB_DISPATCHER_ASSERT_SVH
`define TWO_SERVER_JOB_DISPATCHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSJD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TSJD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`endif

// ===== src/tsjd_pkg.sv =====
// Types and constants of the two-server job dispatcher
package tsjd_pkg;

    localparam int ID_W    = 16;
    localparam int TICK_W  = 16;
    localparam int DUR_W   = 4;
    localparam int COUNT_W = 4;
    localparam int LIMIT_W = 4;
    localparam int SUM_W   = 32;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index taken from paddr[2]
    localparam logic [0:0] REG_QUEUE_LIMIT = 1'b0;

    localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 4'd8;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] stamp;
        logic [DUR_W-1:0]  duration;
    } job_entry_t;

endpackage

// ===== src/job_in_if.sv =====
// Input channel: one tick with an optional job arrival
interface job_in_if;
    logic                        valid;
    logic                        ready;
    logic                        job_arrives;
    logic [tsjd_pkg::DUR_W-1:0]  job_duration;

    modport source (output valid, output job_arrives, output job_duration, input ready);
    modport sink   (input valid, input job_arrives, input job_duration, output ready);
endinterface

// ===== src/tick_out_if.sv =====
// Output channel: per-tick dispatch result
interface tick_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsjd_pkg::TICK_W-1:0]   tick_time;
    logic                          first_started;
    logic [tsjd_pkg::ID_W-1:0]     first_job_id;
    logic [tsjd_pkg::TICK_W-1:0]   first_job_wait;
    logic                          second_started;
    logic [tsjd_pkg::ID_W-1:0]     second_job_id;
    logic [tsjd_pkg::TICK_W-1:0]   second_job_wait;
    logic                          job_dropped;
    logic [tsjd_pkg::COUNT_W-1:0]  waiting_count;
    logic [tsjd_pkg::SUM_W-1:0]    wait_total;

    modport source (
        output valid, output tick_time, output first_started, output first_job_id,
        output first_job_wait, output second_started, output second_job_id,
        output second_job_wait, output job_dropped, output waiting_count,
        output wait_total, input ready
    );
    modport sink (
        input valid, input tick_time, input first_started, input first_job_id,
        input first_job_wait, input second_started, input second_job_id,
        input second_job_wait, input job_dropped, input waiting_count,
        input wait_total, output ready
    );
endinterface

// ===== src/tsjd_job_store.sv =====
// Job queue memory: one write port, two registered read ports with write forwarding
module tsjd_job_store #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  tsjd_pkg::job_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr0,
    input  logic [IDX_W-1:0]     rd_addr1,
    output tsjd_pkg::job_entry_t rd_data0,
    output tsjd_pkg::job_entry_t rd_data1
);

    tsjd_pkg::job_entry_t mem [DEPTH];

    tsjd_pkg::job_entry_t rd0_reg;
    tsjd_pkg::job_entry_t rd1_reg;
    tsjd_pkg::job_entry_t fwd_reg;
    logic                 byp0_reg;
    logic                 byp1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd0_reg  <= mem[rd_addr0];
            rd1_reg  <= mem[rd_addr1];
            fwd_reg  <= wr_data;
            byp0_reg <= wr_en && (wr_addr == rd_addr0);
            byp1_reg <= wr_en && (wr_addr == rd_addr1);
        end
    end

    // entry written in the same cycle it was read comes from the forward register
    assign rd_data0 = byp0_reg ? fwd_reg : rd0_reg;
    assign rd_data1 = byp1_reg ? fwd_reg : rd1_reg;

endmodule

// ===== src/two_server_job_dispatcher.sv =====
// Tick-driven FIFO job queue feeding two servers, with APB queue-limit register
// A tick's result is registered in stage one, then in the output registers.
// Throughput: one tick per cycle unless tick_out stalls; the queue memory is
// read each tick at head and head+1 (head if server 0 pops none) for durations.
// Reset (rst_n low, asynchronous): counters, indices, servers and the wait total
// clear, queue_limit returns to 8; queue memory contents are left as they are.
module two_server_job_dispatcher #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    job_in_if.sink                              job_in,
    tick_out_if.source                          tick_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsjd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tsjd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tsjd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    localparam int TW = tsjd_pkg::TICK_W;
    localparam int CW = tsjd_pkg::COUNT_W;
    localparam int DW = tsjd_pkg::DUR_W;
    localparam int SW = tsjd_pkg::SUM_W;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == LAST_IDX) ? '0 : idx + 1'b1;
        return res;
    endfunction

    // configuration
    logic [tsjd_pkg::LIMIT_W-1:0] limit_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[2] == tsjd_pkg::REG_QUEUE_LIMIT);
    assign prdata = (paddr[2] == tsjd_pkg::REG_QUEUE_LIMIT) ?
                    {{(tsjd_pkg::APB_DATA_W - tsjd_pkg::LIMIT_W){1'b0}}, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tsjd_pkg::QUEUE_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[tsjd_pkg::LIMIT_W-1:0];
        end
    end

    // queue and server state
    logic [TW-1:0]              tick_reg,    tick_next;
    logic [tsjd_pkg::ID_W-1:0]  next_id_reg, next_id_next;
    logic [IDX_W-1:0]           head_reg,    head_next;
    logic [IDX_W-1:0]           tail_reg,    tail_next;
    logic [CW-1:0]              count_reg,   count_next;
    logic [DW-1:0]              rem_reg  [2];
    logic [DW-1:0]              rem_next [2];
    logic [1:0]                 ld_pend_reg, ld_pend_next;

    // pipeline
    logic                       s1_valid_reg;
    logic [TW-1:0]              s1_tick_reg;
    logic [1:0]                 s1_start_reg;
    logic                       s1_drop_reg;
    logic [CW-1:0]              s1_count_reg;
    logic                       out_valid_reg;
    logic [SW-1:0]              wait_sum_reg, wait_sum_next;

    logic                       out_free;
    logic                       s1_move;
    logic                       accept;

    tsjd_pkg::job_entry_t       rd_entry [2];
    tsjd_pkg::job_entry_t       wr_entry;
    logic [IDX_W-1:0]           rd_addr1;

    logic                       push;
    logic                       dropped;
    logic [CW-1:0]              cnt_arr;
    logic [CW-1:0]              cnt_mid;
    logic [DW-1:0]              rem_eff [2];
    logic [1:0]                 pop;

    assign out_free     = !out_valid_reg || tick_out.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign job_in.ready = !s1_valid_reg || out_free;
    assign accept       = job_in.valid && job_in.ready;

    always_comb
    begin
        push    = job_in.job_arrives && (count_reg < limit_reg) &&
                  (32'(count_reg) < QUEUE_DEPTH);
        dropped = job_in.job_arrives && !push;
        cnt_arr = count_reg + CW'(push);

        for (int k = 0; k < 2; k++)
        begin
            rem_eff[k] = ld_pend_reg[k] ? rd_entry[k].duration : rem_reg[k];
        end

        pop[0]  = (rem_eff[0] == '0) && (cnt_arr != '0);
        cnt_mid = cnt_arr - CW'(pop[0]);
        pop[1]  = (rem_eff[1] == '0) && (cnt_mid != '0);

        rd_addr1 = pop[0] ? idx_inc(head_reg) : head_reg;

        wr_entry.id       = next_id_reg;
        wr_entry.stamp    = tick_reg;
        wr_entry.duration = job_in.job_duration;

        tick_next    = tick_reg + 1'b1;
        next_id_next = push ? next_id_reg + 1'b1 : next_id_reg;
        tail_next    = push ? idx_inc(tail_reg) : tail_reg;
        head_next    = pop[1] ? idx_inc(rd_addr1) : rd_addr1;
        count_next   = cnt_mid - CW'(pop[1]);

        for (int k = 0; k < 2; k++)
        begin
            ld_pend_next[k] = pop[k];
            if (pop[k] || rem_eff[k] == '0)
            begin
                rem_next[k] = '0;
            end
            else
            begin
                rem_next[k] = rem_eff[k] - 1'b1;
            end
        end
    end

    tsjd_job_store #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (accept && push),
        .wr_addr  (tail_reg),
        .wr_data  (wr_entry),
        .rd_en    (accept),
        .rd_addr0 (head_reg),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_entry[0]),
        .rd_data1 (rd_entry[1])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            next_id_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rem_reg[0]   <= '0;
            rem_reg[1]   <= '0;
            ld_pend_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_reg    <= tick_next;
                next_id_reg <= next_id_next;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                rem_reg[0]  <= rem_next[0];
                rem_reg[1]  <= rem_next[1];
                ld_pend_reg <= ld_pend_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tick_reg  <= tick_reg;
            s1_start_reg <= pop;
            s1_drop_reg  <= dropped;
            s1_count_reg <= count_next;
        end
    end

    // second stage: waits and saturating total
    logic [TW-1:0]  wait_val [2];
    logic [TW:0]    wait_pair;
    logic [SW:0]    sum_wide;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            wait_val[k] = s1_start_reg[k] ? s1_tick_reg - rd_entry[k].stamp : '0;
        end
        wait_pair     = {1'b0, wait_val[0]} + {1'b0, wait_val[1]};
        sum_wide      = {1'b0, wait_sum_reg} + (SW + 1)'(wait_pair);
        wait_sum_next = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            wait_sum_reg  <= '0;
        end
        else
        begin
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                wait_sum_reg  <= wait_sum_next;
            end
            else if (tick_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            tick_out.tick_time       <= s1_tick_reg;
            tick_out.first_started   <= s1_start_reg[0];
            tick_out.first_job_id    <= s1_start_reg[0] ? rd_entry[0].id : '0;
            tick_out.first_job_wait  <= wait_val[0];
            tick_out.second_started  <= s1_start_reg[1];
            tick_out.second_job_id   <= s1_start_reg[1] ? rd_entry[1].id : '0;
            tick_out.second_job_wait <= wait_val[1];
            tick_out.job_dropped     <= s1_drop_reg;
            tick_out.waiting_count   <= s1_count_reg;
        end
    end

    assign tick_out.valid      = out_valid_reg;
    assign tick_out.wait_total = wait_sum_reg;

endmodule

// ===== src/tsjd_checker.sv =====
// Port-level checker for the dispatcher and its bind
`include "two_server_job_dispatcher_assert.svh"

module tsjd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [tsjd_pkg::TICK_W-1:0]    tick_time,
    input logic                           first_started,
    input logic [tsjd_pkg::ID_W-1:0]      first_job_id,
    input logic [tsjd_pkg::TICK_W-1:0]    first_job_wait,
    input logic                           second_started,
    input logic [tsjd_pkg::ID_W-1:0]      second_job_id,
    input logic [tsjd_pkg::SUM_W-1:0]     wait_total
);

    `TSJD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tick_time) && $stable(wait_total))

    `TSJD_ASSERT_NOW(a_idle_first_zero, out_valid && !first_started, first_job_id == '0 && first_job_wait == '0)

    `TSJD_ASSERT_NOW(a_fifo_order, out_valid && first_started && second_started, second_job_id == tsjd_pkg::ID_W'(first_job_id + 1'b1))

    `TSJD_ASSERT_NOW(a_tick_step, out_valid && out_ready && $past(out_valid && out_ready), tick_time == tsjd_pkg::TICK_W'($past(tick_time) + 1'b1))

    `TSJD_ASSERT_NOW(a_total_grows, out_valid && out_ready && $past(out_valid && out_ready), wait_total >= $past(wait_total))

endmodule

bind two_server_job_dispatcher tsjd_checker u_tsjd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (tick_out.valid),
    .out_ready      (tick_out.ready),
    .tick_time      (tick_out.tick_time),
    .first_started  (tick_out.first_started),
    .first_job_id   (tick_out.first_job_id),
    .first_job_wait (tick_out.first_job_wait),
    .second_started (tick_out.second_started),
    .second_job_id  (tick_out.second_job_id),
    .wait_total     (tick_out.wait_total)
);

// ===== tb/sv/two_server_job_dispatcher_checker.sv =====
// Checker for the two-server job dispatcher: predicts every tick result and compares it
module two_server_job_dispatcher_checker
    import tsjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_REPORTS = 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    job_in_if                       job_in,
    tick_out_if                     tick_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic [APB_DATA_W-1:0]   prdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      outstanding,
    output int                      results_checked,
    output int                      drops_seen,
    output int                      starts_seen
);

    typedef struct packed {
        logic [TICK_W-1:0]  tick_time;
        logic               first_started;
        logic [ID_W-1:0]    first_job_id;
        logic [TICK_W-1:0]  first_job_wait;
        logic               second_started;
        logic [ID_W-1:0]    second_job_id;
        logic [TICK_W-1:0]  second_job_wait;
        logic               job_dropped;
        logic [COUNT_W-1:0] waiting_count;
        logic [SUM_W-1:0]   wait_total;
    } tick_result_t;

    logic [TICK_W-1:0]  tick_ctr;
    logic [ID_W-1:0]    id_ctr;
    job_entry_t         slots [QUEUE_DEPTH];
    int                 head;
    int                 tail;
    int                 filled;
    logic [DUR_W-1:0]   busy_left [2];
    logic [SUM_W-1:0]   wait_acc;
    logic [LIMIT_W-1:0] limit_reg;
    tick_result_t       queued_results [$];
    tick_result_t       predicted;

    // one server's turn: count down if busy, else take the head job
    function automatic void serve(input int s, output logic started,
                                  output logic [ID_W-1:0] id, output logic [TICK_W-1:0] wt);
        job_entry_t     e;
        logic [SUM_W:0] sum;
        started = 1'b0;
        id = '0;
        wt = '0;
        if (busy_left[s] != '0)
            busy_left[s] = busy_left[s] - 1'b1;
        else if (filled != 0)
        begin
            e = slots[head];
            head = (head + 1) % QUEUE_DEPTH;
            filled--;
            busy_left[s] = e.duration;
            started = 1'b1;
            id = e.id;
            wt = tick_ctr - e.stamp;
            sum = {1'b0, wait_acc} + wt;
            wait_acc = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
        end
    endfunction

    function automatic tick_result_t predict_tick(input logic arrives,
                                                  input logic [DUR_W-1:0] dur);
        tick_result_t r;
        r = '0;
        if (arrives)
        begin
            if (filled < int'(limit_reg) && filled < QUEUE_DEPTH)
            begin
                slots[tail] = '{id: id_ctr, stamp: tick_ctr, duration: dur};
                id_ctr = id_ctr + 1'b1;
                tail = (tail + 1) % QUEUE_DEPTH;
                filled++;
            end
            else
                r.job_dropped = 1'b1;
        end
        r.tick_time = tick_ctr;
        serve(0, r.first_started, r.first_job_id, r.first_job_wait);
        serve(1, r.second_started, r.second_job_id, r.second_job_wait);
        r.waiting_count = filled[COUNT_W-1:0];
        r.wait_total = wait_acc;
        tick_ctr = tick_ctr + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ctr = '0;
            id_ctr = '0;
            head = 0;
            tail = 0;
            filled = 0;
            busy_left[0] = '0;
            busy_left[1] = '0;
            wait_acc = '0;
            limit_reg = QUEUE_LIMIT_RESET;
            queued_results.delete();
            fail_count = 0;
            outstanding = 0;
            results_checked = 0;
            drops_seen = 0;
            starts_seen = 0;
        end
        else
        begin
            if (job_in.valid && job_in.ready)
            begin
                predicted = predict_tick(job_in.job_arrives, job_in.job_duration);
                drops_seen += predicted.job_dropped;
                starts_seen += predicted.first_started + predicted.second_started;
                queued_results.push_back(predicted);
            end
            if (tick_out.valid && tick_out.ready)
            begin
                if (queued_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected tick result, tick_time 0x%0h",
                                 $time, tick_out.tick_time);
                    fail_count++;
                end
                else
                begin
                    predicted = queued_results.pop_front();
                    check_field("tick_time", predicted.tick_time, tick_out.tick_time);
                    check_field("first_started", predicted.first_started,
                                tick_out.first_started);
                    check_field("first_job_id", predicted.first_job_id, tick_out.first_job_id);
                    check_field("first_job_wait", predicted.first_job_wait,
                                tick_out.first_job_wait);
                    check_field("second_started", predicted.second_started,
                                tick_out.second_started);
                    check_field("second_job_id", predicted.second_job_id,
                                tick_out.second_job_id);
                    check_field("second_job_wait", predicted.second_job_wait,
                                tick_out.second_job_wait);
                    check_field("job_dropped", predicted.job_dropped, tick_out.job_dropped);
                    check_field("waiting_count", predicted.waiting_count,
                                tick_out.waiting_count);
                    check_field("wait_total", predicted.wait_total, tick_out.wait_total);
                    results_checked++;
                end
            end
            if (psel && penable && pready && paddr[2] == REG_QUEUE_LIMIT)
            begin
                if (pwrite)
                    limit_reg = pwdata[LIMIT_W-1:0];
                else
                    check_field("queue_limit readback",
                                {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_reg}, prdata);
            end
            outstanding = queued_results.size();
        end
    end

endmodule

// ===== tb/sv/two_server_job_dispatcher_tb.sv =====
// Testbench top for the two-server job dispatcher: stimulus, back-pressure and verdict
module two_server_job_dispatcher_tb;
    import tsjd_pkg::*;

    localparam int     QUEUE_DEPTH   = 8;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_TICKS   = 75;
    localparam longint RUN_LIMIT     = 64'd15_000_000;
    localparam int     LIMIT_PLAN [RANDOM_PHASES] = '{8, 1, 15, 4, 0, 2, 8, 5};

    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_QUEUE_LIMIT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   hold_go;

    int fail_count;
    int outstanding;
    int results_checked;
    int drops_seen;
    int starts_seen;
    int limits_used;

    job_in_if   job_in ();
    tick_out_if tick_out ();

    two_server_job_dispatcher #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_in   (job_in),
        .tick_out (tick_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    two_server_job_dispatcher_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_in          (job_in),
        .tick_out        (tick_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .drops_seen      (drops_seen),
        .starts_seen     (starts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random ready modes, plus one long hold-off on request
    initial
    begin
        rx_mode_e rx_mode;
        int       mode_left;
        int       hold_left;
        logic     hold_done;
        rx_mode = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        tick_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                tick_out.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: tick_out.ready <= 1'b1;
                    RX_MOSTLY: tick_out.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: tick_out.ready <= ($urandom_range(0, 3) == 0);
                    default:   tick_out.ready <= !tick_out.ready;
                endcase
            end
        end
    end

    task automatic send_tick(input logic arrives, input logic [DUR_W-1:0] dur);
        job_in.valid <= 1'b1;
        job_in.job_arrives <= arrives;
        job_in.job_duration <= dur;
        do @(posedge clk); while (!job_in.ready);
    endtask

    task automatic pause(input int cycles);
        job_in.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle();
        job_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limit(input int value);
        settle();
        reg_access(1'b1, LIMIT_ADDR, APB_DATA_W'(value));
        limits_used++;
    endtask

    task automatic run_random(input int count);
        int               sent;
        int               burst;
        int               gap;
        int               arrive_pct;
        logic             short_jobs;
        logic             arrives;
        logic [DUR_W-1:0] dur;
        arrive_pct = $urandom_range(25, 95);
        short_jobs = $urandom_range(0, 1);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count)
            begin
                arrives = ($urandom_range(1, 100) <= arrive_pct);
                if (!arrives)
                    dur = DUR_W'($urandom());
                else if ($urandom_range(0, 7) == 0)
                    dur = '0;
                else if (short_jobs)
                    dur = DUR_W'($urandom_range(1, 3));
                else
                    dur = DUR_W'($urandom_range(1, 15));
                send_tick(arrives, dur);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                pause(gap);
        end
    endtask

    initial
    begin
        int p;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        hold_go <= 1'b0;
        job_in.valid <= 1'b0;
        job_in.job_arrives <= 1'b0;
        job_in.job_duration <= '0;
        limits_used = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_access(1'b0, LIMIT_ADDR, '0);
        send_tick(1'b1, 4'd0);
        send_tick(1'b1, 4'd15);
        send_tick(1'b0, 4'd15);
        repeat (11) send_tick(1'b1, 4'd15);
        send_tick(1'b0, 4'd0);
        // limit drops under the current fill
        set_limit(2);
        send_tick(1'b1, 4'd5);
        send_tick(1'b1, 4'd10);
        settle();
        reg_access(1'b1, SPARE_ADDR, '1);
        reg_access(1'b0, LIMIT_ADDR, '0);
        set_limit(0);
        send_tick(1'b1, 4'd1);
        send_tick(1'b1, 4'd14);
        set_limit(15);
        send_tick(1'b1, 4'b0101);
        send_tick(1'b1, 4'b1010);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            set_limit((p == RANDOM_PHASES - 1) ? $urandom_range(0, 15) : LIMIT_PLAN[p]);
            reg_access(1'b0, LIMIT_ADDR, '0);
            if (p == 0)
                hold_go <= 1'b1;
            run_random(PHASE_TICKS);
        end

        settle();
        $display("Run covered %0d tick results under %0d queue limit settings,",
                 results_checked, limits_used);
        $display("with %0d arrivals dropped and %0d jobs served.",
                 drops_seen, starts_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
